// File: hw/rtl/fsc_pkg.sv
// fsc_pkg: shared types and codes for the first-seen id compressor
// word formats, operation and status codes, and the control group passed between cells
// no dependencies
`default_nettype none

package fsc_pkg;

  localparam int KEY_W    = 32;
  localparam int INDEX_W  = 7;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic                    operation;
    logic signed [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  index;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  // control group that rides along the cell chain with each word
  typedef struct packed {
    logic vld;
    op_t  operation;
    logic found;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/fsc_cell.sv
// fsc_cell: one table slot of the compressor chain
// holds one key and its occupied flag, compares the passing word and claims a free slot
// depends on fsc_pkg
`default_nettype none

module fsc_cell #(
  parameter int POS  = 0,
  parameter int IDXW = 7
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire fsc_pkg::cell_ctl_t              up_ctl,
  input  wire logic signed [fsc_pkg::KEY_W-1:0] up_key,
  input  wire logic [IDXW-1:0]                 up_idx,
  output fsc_pkg::cell_ctl_t                   dn_ctl,
  output logic signed [fsc_pkg::KEY_W-1:0]     dn_key,
  output logic [IDXW-1:0]                      dn_idx,
  output logic                                 occupied
);

  logic signed [fsc_pkg::KEY_W-1:0] stored_key;
  logic hit;
  logic claim;

  // slots fill in order, so the first free slot a new key meets is the next one
  assign hit   = up_ctl.vld && occupied && (up_key == stored_key);
  assign claim = up_ctl.vld && !occupied && !up_ctl.found &&
                 (up_ctl.operation == fsc_pkg::OP_ADD);

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied   <= 1'b0;
      dn_ctl.vld <= 1'b0;
    end else begin
      dn_ctl.vld <= up_ctl.vld;
      if (claim) begin
        occupied <= 1'b1;
      end
    end
    if (claim) begin
      stored_key <= up_key;
    end
    dn_ctl.operation <= up_ctl.operation;
    dn_ctl.found     <= up_ctl.found || hit || claim;
    dn_key           <= up_key;
    if (hit || claim) begin
      dn_idx <= IDXW'(POS);
    end else begin
      dn_idx <= up_idx;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/first_seen_id_compressor_core.sv
// first_seen_id_compressor_core: top level of the first-seen id compressor
// input register, chain of fsc_cell slots and result register
// depends on fsc_pkg and fsc_cell
`default_nettype none

// Maps each key to the dense index of its first appearance. A word is taken at
// a clock edge with start high and busy low; busy is high only in the cycle
// after reset. Every word walks down a chain of TABLE_ENTRIES cells, one cell per
// cycle, and each cell holds one key: an add claims the first free cell it meets
// if no earlier cell matched, a lookup only compares. A new word may start in
// every cycle, and its result is on result once the word has passed the input
// register (loaded on the edge that took it), one register per cell and the result
// register, so the chain length sets the latency and the throughput is one word per
// cycle. Results come in input order, each on result for exactly one cycle with
// strobe high; the receiver cannot stall them. Status is ok, lookup miss or table
// full (key dropped); index is zero unless ok and wraps modulo 128 above 128
// entries.

module first_seen_id_compressor_core #(
  parameter int TABLE_ENTRIES = 128
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire fsc_pkg::in_word_t   in_word,
  output logic                     strobe,
  output fsc_pkg::out_word_t       result
);

  localparam int IDXW = $clog2(TABLE_ENTRIES);

  // stage k is the word in front of cell k; stage TABLE_ENTRIES leaves the chain
  fsc_pkg::cell_ctl_t               st_ctl [TABLE_ENTRIES+1];
  logic signed [fsc_pkg::KEY_W-1:0] st_key [TABLE_ENTRIES+1];
  logic [IDXW-1:0]                  st_idx [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0]         occ;
  logic                             accept;
  fsc_pkg::cell_ctl_t               tail;
  fsc_pkg::cell_ctl_t               in_ctl;
  logic signed [fsc_pkg::KEY_W-1:0] in_key;

  assign accept = start && !busy;

  // input register; busy only masks the first cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      in_ctl.vld <= 1'b0;
    end else begin
      busy       <= 1'b0;
      in_ctl.vld <= accept;
    end
    in_ctl.operation <= fsc_pkg::op_t'(in_word.operation);
    in_ctl.found     <= 1'b0;
    in_key           <= in_word.key;
  end

  assign st_ctl[0] = in_ctl;
  assign st_key[0] = in_key;
  assign st_idx[0] = '0;

  // the slot chain
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    fsc_cell #(
      .POS  (g),
      .IDXW (IDXW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_ctl   (st_ctl[g]),
      .up_key   (st_key[g]),
      .up_idx   (st_idx[g]),
      .dn_ctl   (st_ctl[g+1]),
      .dn_key   (st_key[g+1]),
      .dn_idx   (st_idx[g+1]),
      .occupied (occ[g])
    );
  end

  assign tail = st_ctl[TABLE_ENTRIES];

  // result register: a word that found no slot is a miss or a dropped add
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.found) begin
      result.index  <= fsc_pkg::INDEX_W'(st_idx[TABLE_ENTRIES]);
      result.status <= fsc_pkg::ST_OK;
    end else if (tail.operation == fsc_pkg::OP_LOOKUP) begin
      result.index  <= '0;
      result.status <= fsc_pkg::ST_MISS;
    end else begin
      result.index  <= '0;
      result.status <= fsc_pkg::ST_FULL;
    end
  end

  // occupied slots always form a run starting at slot zero
  a_occ_run: assert property (@(posedge clk) disable iff (rst)
    (occ & (occ + 1'b1)) == '0)
    else $error("occupied slots not contiguous from slot zero");

  // each accepted word raises strobe after the input, cell and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(TABLE_ENTRIES+2) strobe)
    else $error("result missing after chain latency");

  // a dropped key is only reported when every slot is taken
  a_full: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status == fsc_pkg::ST_FULL) |-> (&occ))
    else $error("table full reported with free slots");

  // a non-ok result carries index zero and a known status
  a_status: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status != fsc_pkg::ST_OK) |->
      (result.index == '0 &&
       (result.status == fsc_pkg::ST_MISS || result.status == fsc_pkg::ST_FULL)))
    else $error("bad error result");

endmodule

`default_nettype wire
